### design/bhs_pkg.sv
// Package for the bucketed hash set: sizes, command and status codes, state type.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package bhs_pkg;

  // Table geometry
  localparam int MAX_BUCKETS  = 64;
  localparam int BUCKET_DEPTH = 8;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int KEY_W   = 31;
  localparam int STAT_W  = 2;
  localparam int TOTAL_W = 10;
  localparam int CFG_W   = 7;

  // Derived widths
  localparam int BUCKET_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int SLOT_W    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int ADDR_W    = BUCKET_W + SLOT_W;
  localparam int KEY_DEPTH = 1 << ADDR_W;
  localparam int REM_W     = $clog2(MAX_BUCKETS) + 1;
  localparam int BIT_W     = $clog2(KEY_W);
  localparam int SLOT_TOTAL = MAX_BUCKETS * BUCKET_DEPTH;

  localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = CFG_W'(64);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_VREAD,
    ST_VKEY,
    ST_PROBE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } free_slot_t;

  // Lowest-numbered clear bit of a bucket's valid word
  function automatic free_slot_t first_free(input logic [BUCKET_DEPTH-1:0] vword);
    free_slot_t res;
    res.found = 1'b0;
    res.slot  = '0;
    for (int i = BUCKET_DEPTH - 1; i >= 0; i--) begin
      if (!vword[i]) begin
        res.found = 1'b1;
        res.slot  = SLOT_W'(i);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### design/bhs_if.sv
// Valid/ready channel interfaces for the bucketed hash set: command items in,
// result items out. Depends on bhs_pkg for field widths.
`default_nettype none

interface bhs_in_if
  import bhs_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [KEY_W-1:0] key;

  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

interface bhs_out_if
  import bhs_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               success;
  logic [STAT_W-1:0]  status;
  logic [TOTAL_W-1:0] element_total;

  modport source (output valid, output success, output status, output element_total,
                  input ready);
  modport sink   (input valid, input success, input status, input element_total,
                  output ready);
endinterface

`default_nettype wire

### design/bhs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.
`default_nettype none

module bhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### design/bucketed_hash_set.sv
// Bucketed hash set top level: serial modulo unit, bucket probe sequencer and
// slot RAMs. Depends on bhs_pkg, bhs_in_if / bhs_out_if and bhs_ram.
//
//   channel  | dir | handshake         | payload
//   in_ch    | in  | valid/ready       | command[1:0], key[30:0]
//   out_ch   | out | valid/ready       | success, status[1:0], element_total[9:0]
//   cfg      | in  | cfg_we, no wait   | cfg_wdata[6:0] = bucket_count
//
// One item passes through the accepting idle state, the shared restoring-modulo
// step (one key bit a cycle), the valid-word fetch in ST_VREAD and ST_VKEY, 1 to
// 8 key probes through the single read port of the key RAM, and the update state.
// in_ch.ready is high only when the sequencer is idle.
// A result waits in the output register; the next item runs meanwhile and stalls
// in its update cycle until that register is free. Reset clears all row-valid
// flags at once, so no clearing pass is needed.
`default_nettype none

module bucketed_hash_set
  import bhs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  bhs_in_if.sink                in_ch,
  bhs_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]        bcount_r;
  logic [TOTAL_W-1:0]      count_r, count_nxt;
  logic [MAX_BUCKETS-1:0]  row_init_r;
  logic                    out_valid_r;

  cmd_t                    cmd_r;
  logic [KEY_W-1:0]        key_r;
  logic [REM_W-1:0]        div_r;
  logic [REM_W-1:0]        rem_r;
  logic [BIT_W-1:0]        bit_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [BUCKET_DEPTH-1:0] vword_r;
  logic                    hit_r;
  logic [SLOT_W-1:0]       hit_slot_r;
  logic                    succ_r;
  status_t                 stat_r;
  logic [TOTAL_W-1:0]      total_r;

  logic [BUCKET_W-1:0]     bucket;
  logic                    in_fire;
  logic                    out_free;
  logic                    probe_hit;
  logic                    probe_last;
  logic [REM_W-1:0]        rem_sh;
  logic [REM_W-1:0]        rem_step;
  logic [REM_W-1:0]        div_sel;
  free_slot_t              free;

  // RAM ports
  logic                    vrd_en, vwr_en;
  logic [BUCKET_DEPTH-1:0] vrd_data, vwr_data;
  logic                    krd_en, kwr_en;
  logic [ADDR_W-1:0]       krd_addr, kwr_addr;
  logic [KEY_W-1:0]        krd_data;

  // Update results
  logic                    upd_succ;
  status_t                 upd_stat;
  logic                    upd_vwr;

  assign bucket     = rem_r[BUCKET_W-1:0];
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign probe_hit  = vword_r[slot_r] && (krd_data == key_r);
  assign probe_last = (slot_r == SLOT_W'(BUCKET_DEPTH - 1));
  assign free       = first_free(vword_r);

  // Clamp the configured bucket count into 1..MAX_BUCKETS
  always_comb begin
    if (bcount_r == '0) begin
      div_sel = REM_W'(1);
    end else if (32'(bcount_r) > 32'(MAX_BUCKETS)) begin
      div_sel = REM_W'(MAX_BUCKETS);
    end else begin
      div_sel = REM_W'(bcount_r);
    end
  end

  // Shared restoring-modulo step: shift in one key bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_r[REM_W-2:0], key_r[bit_r]};
    if (rem_sh >= div_r) begin
      rem_step = rem_sh - div_r;
    end else begin
      rem_step = rem_sh;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_DIV;
      ST_DIV:    if (bit_r == '0) state_nxt = ST_VREAD;
      ST_VREAD:  state_nxt = ST_VKEY;
      ST_VKEY:   state_nxt = ST_PROBE;
      ST_PROBE:  if (probe_hit || probe_last) state_nxt = ST_UPDATE;
      ST_UPDATE: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and RAM reads
  always_comb begin
    in_ch.ready = 1'b0;
    vrd_en      = 1'b0;
    krd_en      = 1'b0;
    krd_addr    = {bucket, slot_r + SLOT_W'(1)};
    unique case (state_r)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_VREAD: vrd_en = 1'b1;
      ST_VKEY: begin
        krd_en   = 1'b1;
        krd_addr = {bucket, {SLOT_W{1'b0}}};
      end
      ST_PROBE: krd_en = !(probe_hit || probe_last);
      default: begin
      end
    endcase
  end

  // Command action in the update cycle
  always_comb begin
    upd_succ  = 1'b0;
    upd_stat  = STAT_DONE;
    upd_vwr   = 1'b0;
    kwr_en    = 1'b0;
    kwr_addr  = {bucket, free.slot};
    vwr_data  = vword_r;
    count_nxt = count_r;
    unique case (cmd_r)
      CMD_LOOKUP: begin
        upd_succ = hit_r;
        upd_stat = hit_r ? STAT_DONE : STAT_MISS;
      end
      CMD_INSERT: begin
        if (hit_r) begin
          upd_stat = STAT_MISS;
        end else if (free.found) begin
          upd_succ  = 1'b1;
          upd_vwr   = 1'b1;
          kwr_en    = 1'b1;
          vwr_data  = vword_r | (BUCKET_DEPTH'(1) << free.slot);
          count_nxt = count_r + TOTAL_W'(1);
        end else begin
          upd_stat = STAT_FULL;
        end
      end
      CMD_DELETE: begin
        if (hit_r) begin
          upd_succ = 1'b1;
          upd_vwr  = 1'b1;
          vwr_data = vword_r & ~(BUCKET_DEPTH'(1) << hit_slot_r);
          if (count_r != '0) begin
            count_nxt = count_r - TOTAL_W'(1);
          end
        end else begin
          upd_stat = STAT_MISS;
        end
      end
      default: begin
      end
    endcase
  end

  assign vwr_en = (state_r == ST_UPDATE) && out_free && upd_vwr;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bcount_r    <= BUCKET_COUNT_RESET;
      count_r     <= '0;
      row_init_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        bcount_r <= cfg_wdata;
      end
      if ((state_r == ST_UPDATE) && out_free) begin
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
        if (upd_vwr) begin
          row_init_r[bucket] <= 1'b1;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_r <= cmd_t'(in_ch.command);
          key_r <= in_ch.key;
          div_r <= div_sel;
          rem_r <= '0;
          bit_r <= BIT_W'(KEY_W - 1);
          hit_r <= 1'b0;
        end
      end
      ST_DIV: begin
        rem_r <= rem_step;
        bit_r <= bit_r - BIT_W'(1);
      end
      ST_VKEY: begin
        vword_r <= row_init_r[bucket] ? vrd_data : '0;
        slot_r  <= '0;
      end
      ST_PROBE: begin
        if (probe_hit) begin
          hit_r      <= 1'b1;
          hit_slot_r <= slot_r;
        end else if (!probe_last) begin
          slot_r <= slot_r + SLOT_W'(1);
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          succ_r  <= upd_succ;
          stat_r  <= upd_stat;
          total_r <= count_nxt;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.success       = succ_r;
  assign out_ch.status        = stat_r;
  assign out_ch.element_total = total_r;

  // Valid words, one per bucket
  bhs_ram #(
    .WIDTH (BUCKET_DEPTH),
    .DEPTH (MAX_BUCKETS)
  ) u_valid_ram (
    .clk     (clk),
    .wr_en   (vwr_en),
    .wr_addr (bucket),
    .wr_data (vwr_data),
    .rd_en   (vrd_en),
    .rd_addr (bucket),
    .rd_data (vrd_data)
  );

  // Slot keys, addressed by bucket and slot
  bhs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (kwr_en && (state_r == ST_UPDATE) && out_free),
    .wr_addr (kwr_addr),
    .wr_data (key_r),
    .rd_en   (krd_en),
    .rd_addr (krd_addr),
    .rd_data (krd_data)
  );

`ifndef NO_ASSERTIONS
  // Stored count never exceeds the slot total
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= SLOT_TOTAL)
    else $error("element count above slot total");

  // An accepted item starts the modulo step
  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_DIV))
    else $error("accepted item did not start division");

  // Remainder is reduced once the modulo step finishes
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VREAD) |-> (rem_r < div_r))
    else $error("bucket index out of range");

  // Count changes only in the update cycle
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_UPDATE) |=> $stable(count_r))
    else $error("element count changed outside update");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking bench for the bucketed hash set: directed table, full-table fill,
// then random command mixes under several bucket counts. Depends on bhs_pkg,
// bhs_in_if / bhs_out_if and the bucketed_hash_set RTL.
`timescale 1ns / 100ps

module tb_top;
  import bhs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 600;
  localparam int PHASE_ITEMS   = 110;
  localparam int DIR_N         = 22;

  typedef struct packed {
    logic               success;
    status_t            status;
    logic [TOTAL_W-1:0] total;
  } outcome_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [KEY_W-1:0]   key;
    logic               typed;
    logic               success;
    status_t            status;
    logic [TOTAL_W-1:0] total;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  bhs_in_if  in_ch ();
  bhs_out_if out_ch ();

  bucketed_hash_set uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Shadow copy of the table and its register
  logic [KEY_W-1:0]   slot_key  [SLOT_TOTAL];
  bit                 slot_used [SLOT_TOTAL];
  logic [TOTAL_W-1:0] key_count = '0;
  logic [CFG_W-1:0]   bucket_cfg = BUCKET_COUNT_RESET;

  outcome_t pending_results [$];

  int items_sent   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int cfg_writes   = 0;
  int hits         = 0;
  int misses       = 0;
  int full_drops   = 0;
  int peak_count   = 0;
  int burst_left   = 0;
  int hold_reqs    = 0;
  int holds_taken  = 0;
  int hold_left    = 0;
  int rx_cycle     = 0;
  int rx_mode      = 0;

  // Directed rows; typed expectations only where obvious
  vector_t dir_tab [DIR_N] = '{
    '{CMD_LOOKUP, 31'd0,          1'b1, 1'b0, STAT_MISS, 10'd0},  // empty after reset
    '{CMD_DELETE, 31'h7FFF_FFFF,  1'b1, 1'b0, STAT_MISS, 10'd0},
    '{CMD_UNUSED, 31'd0,          1'b1, 1'b0, STAT_DONE, 10'd0},
    '{CMD_INSERT, 31'd0,          1'b1, 1'b1, STAT_DONE, 10'd1},
    '{CMD_INSERT, 31'd0,          1'b1, 1'b0, STAT_MISS, 10'd1},  // duplicate
    '{CMD_LOOKUP, 31'd0,          1'b0, 1'b0, STAT_DONE, 10'd0},
    '{CMD_INSERT, 31'h7FFF_FFFF,  1'b1, 1'b1, STAT_DONE, 10'd2},  // largest key
    '{CMD_UNUSED, 31'h7FFF_FFFF,  1'b1, 1'b0, STAT_DONE, 10'd2},
    '{CMD_INSERT, 31'd64,         1'b0, 1'b0, STAT_DONE, 10'd0},
    '{CMD_INSERT, 31'd128,        1'b0, 1'b0, STAT_DONE, 10'd0},
    '{CMD_INSERT, 31'd192,        1'b0, 1'b0, STAT_DONE, 10'd0},
    '{CMD_INSERT, 31'd256,        1'b0, 1'b0, STAT_DONE, 10'd0},
    '{CMD_INSERT, 31'd320,        1'b0, 1'b0, STAT_DONE, 10'd0},
    '{CMD_INSERT, 31'd384,        1'b0, 1'b0, STAT_DONE, 10'd0},
    '{CMD_INSERT, 31'd448,        1'b0, 1'b0, STAT_DONE, 10'd0},
    '{CMD_INSERT, 31'd512,        1'b1, 1'b0, STAT_FULL, 10'd9},  // bucket 0 full
    '{CMD_DELETE, 31'd192,        1'b0, 1'b0, STAT_DONE, 10'd0},
    '{CMD_INSERT, 31'd512,        1'b0, 1'b0, STAT_DONE, 10'd0},  // reuses freed slot
    '{CMD_LOOKUP, 31'd512,        1'b0, 1'b0, STAT_DONE, 10'd0},
    '{CMD_LOOKUP, 31'd192,        1'b0, 1'b0, STAT_DONE, 10'd0},
    '{CMD_DELETE, 31'h7FFF_FFFF,  1'b0, 1'b0, STAT_DONE, 10'd0},
    '{CMD_LOOKUP, 31'h7FFF_FFFF,  1'b0, 1'b0, STAT_DONE, 10'd0}
  };

  function automatic int unsigned live_buckets();
    if (bucket_cfg == 0) return 1;
    if (bucket_cfg > MAX_BUCKETS) return MAX_BUCKETS;
    return bucket_cfg;
  endfunction

  // Apply one command to the shadow table and return its outcome
  function automatic outcome_t apply_command(input logic [CMD_W-1:0] cmd,
                                             input logic [KEY_W-1:0] key);
    outcome_t res;
    int unsigned base;
    int hit;
    int free_slot;
    base = (key % live_buckets()) * BUCKET_DEPTH;
    hit = -1;
    free_slot = -1;
    for (int i = BUCKET_DEPTH - 1; i >= 0; i--) begin
      if (slot_used[base + i] && slot_key[base + i] == key) hit = base + i;
      if (!slot_used[base + i]) free_slot = base + i;
    end
    res.success = 1'b0;
    res.status  = STAT_DONE;
    case (cmd)
      CMD_LOOKUP: begin
        if (hit >= 0) res.success = 1'b1;
        else res.status = STAT_MISS;
      end
      CMD_INSERT: begin
        if (hit >= 0) begin
          res.status = STAT_MISS;
        end else if (free_slot < 0) begin
          res.status = STAT_FULL;
        end else begin
          slot_used[free_slot] = 1'b1;
          slot_key[free_slot]  = key;
          key_count++;
          res.success = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          if (key_count != 0) key_count--;
          res.success = 1'b1;
        end else begin
          res.status = STAT_MISS;
        end
      end
      default: ;
    endcase
    res.total = key_count;
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return KEY_W'($urandom());
  endfunction

  // Random key that lands in bucket b of n
  function automatic logic [KEY_W-1:0] bucket_key(input int unsigned b, input int unsigned n);
    int unsigned m;
    m = $urandom_range(0, (32'h7FFF_FFFF - b) / n);
    return KEY_W'(b + n * m);
  endfunction

  // Offer one item, record its expected result on acceptance, then maybe idle
  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                       input logic typed, input outcome_t typed_res);
    outcome_t pred;
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.key     <= key;
    do @(posedge clk); while (!in_ch.ready);
    pred = apply_command(cmd, key);
    pending_results.push_back(typed ? typed_res : pred);
    items_sent++;
    if (pred.status == STAT_FULL) full_drops++;
    else if (pred.success) hits++;
    else if (cmd != CMD_UNUSED) misses++;
    if (key_count > peak_count) peak_count = key_count;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 90) : $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_buckets(input logic [CFG_W-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we     <= 1'b0;
    bucket_cfg = value;
    cfg_writes++;
  endtask

  // Delete every stored key, searched under the current bucket count
  task automatic clear_table();
    logic [KEY_W-1:0] doomed [$];
    for (int s = 0; s < SLOT_TOTAL; s++)
      if (slot_used[s]) doomed.push_back(slot_key[s]);
    foreach (doomed[i]) offer(CMD_DELETE, doomed[i], 1'b0, '0);
  endtask

  // Receiver: long hold-offs on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    rx_cycle++;
    if (hold_reqs != holds_taken) begin
      holds_taken++;
      hold_left = HOLD_CYCLES;
    end
    if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= (rx_cycle % 7) < 4;
        default: out_ch.ready <= (rx_cycle % 64) >= 48;
      endcase
    end
  end

  function automatic void field_check(input string name, input logic [TOTAL_W-1:0] want,
                                      input logic [TOTAL_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Compare each returned item with the oldest expectation
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with none expected, got success %0d status %0d total %0d",
                 $time, out_ch.success, out_ch.status, out_ch.element_total);
      end else begin
        want = pending_results.pop_front();
        field_check("success", TOTAL_W'(want.success), TOTAL_W'(out_ch.success));
        field_check("status", TOTAL_W'(want.status), TOTAL_W'(out_ch.status));
        field_check("element_total", want.total, out_ch.element_total);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    outcome_t typed_res;
    logic [KEY_W-1:0] pool [16];
    logic [CFG_W-1:0] phase_cfg [9];
    int unsigned live;
    int unsigned hot_a;
    int unsigned hot_b;
    int unsigned pick;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.command = '0;
    in_ch.key     = '0;
    foreach (slot_used[s]) slot_used[s] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table at the reset bucket count
    foreach (dir_tab[i]) begin
      typed_res.success = dir_tab[i].success;
      typed_res.status  = dir_tab[i].status;
      typed_res.total   = dir_tab[i].total;
      offer(dir_tab[i].cmd, dir_tab[i].key, dir_tab[i].typed, typed_res);
    end
    drain();

    // Empty the table, fill every slot of every bucket, then insert one more key
    write_buckets(7'd64);
    clear_table();
    for (int d = 0; d < BUCKET_DEPTH; d++)
      for (int b = 0; b < MAX_BUCKETS; b++)
        offer(CMD_INSERT, bucket_key(b, MAX_BUCKETS), 1'b0, '0);
    offer(CMD_INSERT, bucket_key($urandom_range(0, MAX_BUCKETS - 1), MAX_BUCKETS), 1'b0, '0);

    // Hold off the receiver while items keep coming so the block backs up
    drain();
    hold_reqs++;
    burst_left = 16;
    for (int i = 0; i < 12; i++)
      offer(CMD_LOOKUP, bucket_key($urandom_range(0, MAX_BUCKETS - 1), MAX_BUCKETS), 1'b0, '0);
    drain();
    clear_table();
    drain();

    // Random mixes; keys stay stored across bucket count changes
    phase_cfg = '{7'd0, 7'd127, 7'd1, 7'd3, 7'd65, 7'd17, 7'd2, 7'd64, 7'd0};
    phase_cfg[8] = CFG_W'($urandom_range(1, MAX_BUCKETS));
    foreach (phase_cfg[p]) begin
      write_buckets(phase_cfg[p]);
      live  = live_buckets();
      hot_a = $urandom_range(0, live - 1);
      hot_b = $urandom_range(0, live - 1);
      foreach (pool[i]) begin
        if (i < 6) pool[i] = bucket_key(hot_a, live);
        else if (i < 11) pool[i] = bucket_key(hot_b, live);
        else pool[i] = rand_key();
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) cmd = CMD_INSERT;
        else if (pick < 65) cmd = CMD_DELETE;
        else if (pick < 95) cmd = CMD_LOOKUP;
        else cmd = CMD_UNUSED;
        key = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 15)] : rand_key();
        offer(cmd, key, 1'b0, '0);
      end
      drain();
    end

    $display("Sent %0d items, checked %0d results over %0d bucket count writes.",
             items_sent, results_seen, cfg_writes);
    $display("Hits %0d, misses %0d, full-bucket drops %0d, peak element count %0d.",
             hits, misses, full_drops, peak_count);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
